### rtl/core/rae_pkg.sv
// Package for the register ALU execute block: sizes, opcodes and status codes.
// No dependencies; used by the channel interfaces and register_alu_execute.
`default_nettype none

package rae_pkg;

    localparam int NUM_REGS   = 16;
    localparam int DATA_WIDTH = 16;
    localparam int REG_IDX_W  = $clog2(NUM_REGS);
    localparam int SH_W       = $clog2(DATA_WIDTH);
    localparam int CNT_W      = $clog2(DATA_WIDTH);
    localparam int PC_W       = 16;
    localparam int FIELD_W    = 16;

    localparam logic [PC_W-1:0]    PC_STEP     = PC_W'(16);
    localparam logic [FIELD_W-1:0] TRAP_NUMBER = FIELD_W'(8'h80);

    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [PC_W-1:0]       pc_t;

    typedef enum logic [3:0] {
        OP_END = 4'd0,
        OP_ADD = 4'd1,
        OP_SUB = 4'd2,
        OP_MUL = 4'd3,
        OP_DIV = 4'd4,
        OP_AND = 4'd5,
        OP_OR  = 4'd6,
        OP_SHL = 4'd7,
        OP_SHR = 4'd8,
        OP_NOT = 4'd9,
        OP_MOV = 4'd10,
        OP_INT = 4'd11
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_END         = 3'd1,
        ST_UNSUPPORTED = 3'd2,
        ST_DIVZERO     = 3'd3,
        ST_TRAP        = 3'd4
    } status_t;

endpackage

`default_nettype wire

### rtl/core/rae_if.sv
// Valid/ready channel interfaces for register_alu_execute: instruction,
// result and configuration write. Depends on rae_pkg.
`default_nettype none

interface rae_instr_if;
    import rae_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [3:0]           cmd;
    logic [3:0]           dest_reg;
    logic                 src_is_immediate;
    logic [3:0]           src_reg;
    logic [FIELD_W-1:0]   immediate;

    modport source (output valid, cmd, dest_reg, src_is_immediate, src_reg, immediate,
                    input ready);
    modport sink   (input valid, cmd, dest_reg, src_is_immediate, src_reg, immediate,
                    output ready);
endinterface

interface rae_result_if;
    import rae_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [2:0]           status;
    logic [FIELD_W-1:0]   written_value;
    logic [PC_W-1:0]      next_pc;

    modport source (output valid, status, written_value, next_pc, input ready);
    modport sink   (input valid, status, written_value, next_pc, output ready);
endinterface

interface rae_cfg_if;
    import rae_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [PC_W-1:0]      data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

### rtl/core/register_alu_execute.sv
// Register ALU execute: 16 x 16-bit register file, program counter, iterative mul/div.
// Steps: an accepted instruction goes through fetch and write, with iterate between
// them for mul and for div by a nonzero source (one shared adder, one bit per cycle).
// Write waits for a free result slot; ready only in idle, one instruction at a time.
// Reset: registers read as zero (per-entry valid bits), pc cleared; a config
// transfer loads pc with the written start address.
`default_nettype none

module register_alu_execute (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rae_instr_if.sink  instr,
    rae_result_if.source result,
    rae_cfg_if.sink    cfg
);
    import rae_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_ITER,
        S_WRITE
    } state_t;

    state_t                state_reg;
    logic [REG_IDX_W-1:0]  rd_idx_reg;
    logic [REG_IDX_W-1:0]  rs_idx_reg;
    opcode_t               cmd_reg;
    logic                  imm_sel_reg;
    logic [FIELD_W-1:0]    imm_reg;
    data_t                 rd_data_reg;
    data_t                 rs_data_reg;
    logic [NUM_REGS-1:0]   valid_reg;
    data_t                 opa_reg;
    data_t                 opb_reg;
    data_t                 acc_reg;
    data_t                 res_reg;
    logic [CNT_W-1:0]      cnt_reg;
    status_t               status_reg;
    logic                  advance_reg;
    pc_t                   pc_reg;
    logic                  out_valid_reg;
    status_t               out_status_reg;
    logic [FIELD_W-1:0]    out_value_reg;
    pc_t                   out_pc_reg;

    data_t                 rf_mem [NUM_REGS];

    logic                  in_xfer;
    logic                  out_free;
    logic                  rf_we;
    data_t                 d_val;
    data_t                 src_val;
    logic                  src_big;
    logic [DATA_WIDTH:0]   add_x;
    logic [DATA_WIDTH:0]   add_y;
    logic                  add_sub;
    logic [DATA_WIDTH+1:0] add_sum;
    logic                  div_neg;
    logic                  iter_last;
    logic                  is_iter_op;

    data_t                 res_next;
    status_t               status_next;
    logic                  advance_next;

    assign instr.ready   = (state_reg == S_IDLE);
    assign in_xfer       = instr.valid && instr.ready;
    assign cfg.ready     = 1'b1;
    assign out_free      = !out_valid_reg || result.ready;
    assign rf_we         = (state_reg == S_WRITE) && out_free;

    assign result.valid         = out_valid_reg;
    assign result.status        = out_status_reg;
    assign result.written_value = out_value_reg;
    assign result.next_pc       = out_pc_reg;

    assign d_val   = valid_reg[rd_idx_reg] ? rd_data_reg : '0;
    assign src_val = imm_sel_reg ? DATA_WIDTH'(imm_reg)
                   : (valid_reg[rs_idx_reg] ? rs_data_reg : '0);
    assign src_big = (src_val >= DATA_WIDTH'(DATA_WIDTH));
    assign is_iter_op = (cmd_reg == OP_MUL) || ((cmd_reg == OP_DIV) && (src_val != '0));
    assign iter_last  = (cnt_reg == CNT_W'(DATA_WIDTH - 1));

    // shared adder: add/sub in fetch, shift-add multiply or restoring divide step in iter
    always_comb
    begin
        add_x   = (DATA_WIDTH+1)'(d_val);
        add_y   = (DATA_WIDTH+1)'(src_val);
        add_sub = (cmd_reg == OP_SUB);
        if (state_reg == S_ITER)
        begin
            if (cmd_reg == OP_MUL)
            begin
                add_x   = {1'b0, acc_reg[DATA_WIDTH-2:0], 1'b0};
                add_y   = opb_reg[DATA_WIDTH-1] ? (DATA_WIDTH+1)'(opa_reg) : '0;
                add_sub = 1'b0;
            end
            else
            begin
                add_x   = {acc_reg, opa_reg[DATA_WIDTH-1]};
                add_y   = (DATA_WIDTH+1)'(opb_reg);
                add_sub = 1'b1;
            end
        end
    end

    assign add_sum = {1'b0, add_x}
                   + (add_sub ? ~{1'b0, add_y} : {1'b0, add_y})
                   + (DATA_WIDTH+2)'(add_sub);
    assign div_neg = add_sum[DATA_WIDTH+1];

    always_comb
    begin
        res_next     = d_val;
        status_next  = ST_OK;
        advance_next = 1'b1;
        unique case (cmd_reg)
            OP_END:
            begin
                status_next  = ST_END;
                advance_next = 1'b0;
            end
            OP_ADD, OP_SUB: res_next = add_sum[DATA_WIDTH-1:0];
            OP_MUL: res_next = d_val;
            OP_DIV:
            begin
                if (src_val == '0)
                    status_next = ST_DIVZERO;
            end
            OP_AND: res_next = d_val & src_val;
            OP_OR:  res_next = d_val | src_val;
            OP_SHL: res_next = src_big ? '0 : (d_val << src_val[SH_W-1:0]);
            OP_SHR: res_next = src_big ? '0 : (d_val >> src_val[SH_W-1:0]);
            OP_NOT: res_next = (d_val == '0) ? DATA_WIDTH'(1) : '0;
            OP_MOV: res_next = src_val;
            OP_INT:
            begin
                if (imm_sel_reg && (imm_reg == TRAP_NUMBER))
                    status_next = ST_TRAP;
            end
            default:
            begin
                status_next  = ST_UNSUPPORTED;
                advance_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            rd_data_reg <= rf_mem[REG_IDX_W'(instr.dest_reg)];
            rs_data_reg <= rf_mem[REG_IDX_W'(instr.src_reg)];
        end
        if (rf_we)
            rf_mem[rd_idx_reg] <= res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && result.ready)
                out_valid_reg <= 1'b0;
            if (cfg.valid && cfg.ready)
                pc_reg <= cfg.data;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        cmd_reg     <= opcode_t'(instr.cmd);
                        rd_idx_reg  <= REG_IDX_W'(instr.dest_reg);
                        rs_idx_reg  <= REG_IDX_W'(instr.src_reg);
                        imm_sel_reg <= instr.src_is_immediate;
                        imm_reg     <= instr.immediate;
                        state_reg   <= S_FETCH;
                    end
                end
                S_FETCH:
                begin
                    res_reg     <= res_next;
                    status_reg  <= status_next;
                    advance_reg <= advance_next;
                    opa_reg     <= d_val;
                    opb_reg     <= src_val;
                    acc_reg     <= '0;
                    cnt_reg     <= '0;
                    state_reg   <= is_iter_op ? S_ITER : S_WRITE;
                end
                S_ITER:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cmd_reg == OP_MUL)
                    begin
                        acc_reg <= add_sum[DATA_WIDTH-1:0];
                        opb_reg <= {opb_reg[DATA_WIDTH-2:0], 1'b0};
                        if (iter_last)
                            res_reg <= add_sum[DATA_WIDTH-1:0];
                    end
                    else
                    begin
                        acc_reg <= div_neg ? add_x[DATA_WIDTH-1:0] : add_sum[DATA_WIDTH-1:0];
                        opa_reg <= {opa_reg[DATA_WIDTH-2:0], !div_neg};
                        if (iter_last)
                            res_reg <= {opa_reg[DATA_WIDTH-2:0], !div_neg};
                    end
                    if (iter_last)
                        state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    if (out_free)
                    begin
                        valid_reg[rd_idx_reg] <= 1'b1;
                        out_valid_reg         <= 1'b1;
                        out_status_reg        <= status_reg;
                        out_value_reg         <= FIELD_W'(res_reg);
                        out_pc_reg            <= advance_reg ? pc_reg + PC_STEP : pc_reg;
                        if (advance_reg)
                            pc_reg <= pc_reg + PC_STEP;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_result_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_WRITE))
        else $error("result appeared outside the write step");

    a_pc_moves_legally: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg != $past(pc_reg)) |->
            ($past(cfg.valid && cfg.ready) || (pc_reg == $past(pc_reg) + PC_STEP)))
        else $error("program counter changed without step or config transfer");

    a_accept_to_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == S_FETCH))
        else $error("accepted instruction did not enter fetch");

    a_iter_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ITER) |=> (state_reg == S_ITER || state_reg == S_WRITE))
        else $error("iteration left to an illegal state");

    a_result_pc_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (out_pc_reg == pc_reg))
        else $error("reported pc differs from program counter");

endmodule

`default_nettype wire
